>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_AT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> rtl/ngte_pkg.sv
package ngte_pkg;

  localparam int FIELD_CHAR_LIMIT = 16;
  localparam int CNT_W            = $clog2(FIELD_CHAR_LIMIT + 1);
  localparam int DIGIT_COUNT      = 6;
  localparam int FOLD_MIN_CHARS   = 7;
  localparam int HOUR_FOLD        = 12;

  localparam int QUEUE_DEPTH      = 2;
  localparam int QPTR_W           = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

  localparam int REPORT_LEN       = 14;
  localparam int IDX_W            = $clog2(REPORT_LEN);

  localparam int ZONE_W           = 4;
  localparam logic [ZONE_W-1:0] ZONE_RESET = 4'd4;

  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_G       = 8'h47;
  localparam logic [7:0] CH_P       = 8'h50;
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] HEX_ALPHA_ADJ = 8'h37;

  typedef logic [3:0] nibble_t;

  // digit[0] is hour tens, digit[5] is second ones
  typedef struct packed {
    nibble_t [DIGIT_COUNT-1:0] digit;
  } report_t;

  typedef struct packed {
    logic full;
    logic avail;
  } q_status_t;

endpackage

>>> rtl/ngte_byte_if.sv
interface ngte_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

>>> rtl/ngte_report_if.sv
interface ngte_report_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_of_report;

  modport source (output valid, output tx_byte, output last_of_report, input ready);
  modport sink (input valid, input tx_byte, input last_of_report, output ready);
endinterface

>>> rtl/ngte_front.sv
`include "assert_macros.svh"

module ngte_front
  import ngte_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  ngte_byte_if.sink         in_ch,
  input  logic              cfg_we,
  input  logic [ZONE_W-1:0] cfg_wdata,
  input  q_status_t         q_stat,
  output logic              push,
  output report_t           push_rec
);

  typedef enum logic [10:0] {
    PH_HUNT  = 11'b000_0000_0001,
    PH_G1    = 11'b000_0000_0010,
    PH_P     = 11'b000_0000_0100,
    PH_G2    = 11'b000_0000_1000,
    PH_G3    = 11'b000_0001_0000,
    PH_A     = 11'b000_0010_0000,
    PH_COMMA = 11'b000_0100_0000,
    PH_TIME  = 11'b000_1000_0000,
    PH_STAR  = 11'b001_0000_0000,
    PH_SUMH  = 11'b010_0000_0000,
    PH_SUML  = 11'b100_0000_0000
  } phase_t;

  function automatic nibble_t hex_nibble(input logic [7:0] c);
    logic [7:0] adj;
    adj = c - HEX_ALPHA_ADJ;
    return (c > CH_NINE) ? adj[3:0] : c[3:0];
  endfunction

  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  report_t           digits_r, digits_nxt;
  logic [7:0]        xor_r, xor_nxt;
  logic [7:0]        saved_r, saved_nxt;
  nibble_t           sumh_r, sumh_nxt;
  logic [ZONE_W-1:0] zone_r;

  logic       acc;
  logic [7:0] c;

  // hour fold, from the stored digits and the zone offset
  logic [7:0] h_raw, h_m, h_a;
  logic [8:0] h_diff;
  logic       h_big;
  nibble_t    fold_tens, fold_ones;
  logic [8:0] h_less10;

  assign in_ch.ready = !q_stat.full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign c           = in_ch.rx_byte;

  always_comb begin
    h_raw     = 8'({4'd0, digits_r.digit[0]} * 8'd10) + {4'd0, digits_r.digit[1]};
    h_m       = (h_raw > 8'(HOUR_FOLD)) ? h_raw - 8'(HOUR_FOLD) : h_raw;
    h_a       = (h_m <= {4'd0, zone_r}) ? h_m + 8'(HOUR_FOLD) : h_m;
    h_diff    = {1'b0, h_a} - {5'd0, zone_r};
    // a negative difference wraps to a huge value, so it folds as well
    h_big     = h_diff[8] || (h_diff > 9'd9);
    h_less10  = h_diff - 9'd10;
    fold_tens = h_big ? 4'd1 : 4'd0;
    fold_ones = h_big ? h_less10[3:0] : h_diff[3:0];
  end

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    digits_nxt = digits_r;
    xor_nxt    = xor_r;
    saved_nxt  = saved_r;
    sumh_nxt   = sumh_r;
    push       = 1'b0;
    if (acc) begin
      if (c != CH_STAR) xor_nxt = xor_r ^ c;
      unique case (phase_r)
        PH_G1: phase_nxt = (c == CH_G) ? PH_P : PH_HUNT;
        PH_P:  phase_nxt = (c == CH_P) ? PH_G2 : PH_HUNT;
        PH_G2: phase_nxt = (c == CH_G) ? PH_G3 : PH_HUNT;
        PH_G3: phase_nxt = (c == CH_G) ? PH_A : PH_HUNT;
        PH_A:  phase_nxt = (c == CH_A) ? PH_COMMA : PH_HUNT;
        PH_COMMA: begin
          cnt_nxt   = '0;
          phase_nxt = (c == CH_COMMA) ? PH_TIME : PH_HUNT;
        end
        PH_TIME: begin
          if (c == CH_COMMA) begin
            if (cnt_r > CNT_W'(FOLD_MIN_CHARS)) begin
              digits_nxt.digit[0] = fold_tens;
              digits_nxt.digit[1] = fold_ones;
            end
            cnt_nxt   = '0;
            phase_nxt = PH_STAR;
          end else if (cnt_r < CNT_W'(FIELD_CHAR_LIMIT)) begin
            if (cnt_r < CNT_W'(DIGIT_COUNT)) digits_nxt.digit[cnt_r[2:0]] = c[3:0];
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        PH_STAR: begin
          if (c == CH_STAR) begin
            saved_nxt = xor_r;
            phase_nxt = PH_SUMH;
          end
        end
        PH_SUMH: begin
          sumh_nxt  = hex_nibble(c);
          phase_nxt = PH_SUML;
        end
        PH_SUML: begin
          push       = (saved_r == {sumh_r, hex_nibble(c)});
          digits_nxt = '0;
          phase_nxt  = PH_HUNT;
        end
        default: begin
          phase_nxt = (c == CH_DOLLAR) ? PH_G1 : PH_HUNT;
          xor_nxt   = '0;
        end
      endcase
    end
  end

  assign push_rec = digits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      cnt_r    <= '0;
      digits_r <= '0;
      xor_r    <= '0;
      saved_r  <= '0;
      sumh_r   <= '0;
      zone_r   <= ZONE_RESET;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      digits_r <= digits_nxt;
      xor_r    <= xor_nxt;
      saved_r  <= saved_nxt;
      sumh_r   <= sumh_nxt;
      if (cfg_we) zone_r <= cfg_wdata;
    end
  end

  `ASSERT_AT(a_push_restarts, push |=> (phase_r == PH_HUNT), "report push must restart the hunt")
  `ASSERT_NEVER(a_push_full, push && q_stat.full, "report pushed into a full queue")

endmodule

>>> rtl/ngte_queue.sv
`include "assert_macros.svh"

module ngte_queue
  import ngte_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  report_t   push_rec,
  input  logic      pop,
  output report_t   head_rec,
  output q_status_t q_stat
);

  report_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head_rec     = slot_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.avail = (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `ASSERT_NEVER(a_cnt_range, cnt_r > QCNT_W'(QUEUE_DEPTH), "queue count beyond depth")
  `ASSERT_AT(a_cnt_grow, (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1), "queue count lost a push")

endmodule

>>> rtl/ngte_back.sv
`include "assert_macros.svh"

module ngte_back
  import ngte_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  q_status_t  q_stat,
  input  report_t    head_rec,
  output logic       pop,
  ngte_report_if.source out_ch
);

  function automatic logic [7:0] report_byte(input report_t r, input logic [IDX_W-1:0] i);
    logic [7:0] b;
    if (i == IDX_W'(REPORT_LEN - 1))       b = CH_LF;
    else if (i == IDX_W'(REPORT_LEN - 2))  b = CH_CR;
    else if (i[0])                         b = CH_ZERO + {4'd0, r.digit[i[IDX_W-1:1]]};
    else                                   b = CH_P + {5'd0, i[IDX_W-1:1]};
    return b;
  endfunction

  logic              busy_r;
  logic [IDX_W-1:0]  idx_r;
  report_t           rec_r;
  logic              fire, last, load;

  assign fire = busy_r && out_ch.ready;
  assign last = (idx_r == IDX_W'(REPORT_LEN - 1));
  // take the next report as soon as the current one hands over its last byte
  assign load = q_stat.avail && (!busy_r || (fire && last));
  assign pop  = load;

  assign out_ch.valid          = busy_r;
  assign out_ch.tx_byte        = report_byte(rec_r, idx_r);
  assign out_ch.last_of_report = last;

  always_ff @(posedge clk) begin
    if (load) rec_r <= head_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (fire) begin
      if (last) busy_r <= 1'b0;
      else      idx_r  <= idx_r + 1'b1;
    end
  end

  `ASSERT_AT(a_drain_idle, (fire && last && !q_stat.avail) |=> !busy_r, "serializer stuck after last byte")

endmodule

>>> rtl/nmea_gga_time_extractor.sv
// With the serializer idle, the edge that accepts the low checksum digit writes the report
// into the queue; the serializer then loads it, and its first byte is valid once loaded.
// Throughput: one input byte per cycle; one report byte per cycle while out ready is high.
// A queue of two reports sits between parser and serializer; input stalls only when it is full.
// Reset: synchronous on rst_n low; parser hunts for '$', queue empties, offset returns to 4.
module nmea_gga_time_extractor
  import ngte_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  ngte_byte_if.sink         in_ch,
  ngte_report_if.source     out_ch,
  input  logic              cfg_we,
  input  logic [ZONE_W-1:0] cfg_wdata
);

  q_status_t q_stat;
  logic      push, pop;
  report_t   push_rec, head_rec;

  ngte_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_stat   (q_stat),
    .push     (push),
    .push_rec (push_rec)
  );

  ngte_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_rec(push_rec),
    .pop     (pop),
    .head_rec(head_rec),
    .q_stat  (q_stat)
  );

  ngte_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_stat  (q_stat),
    .head_rec(head_rec),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
